@@ design/assert_macros.svh @@
// Assertion macros shared by the rank indexer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define VRI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Expression must never be true outside reset.
`define VRI_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

@@ design/vri_pkg.sv @@
// Types and constants for the value rank indexer.
`default_nettype none
package vri_pkg;

   localparam int VALUE_W = 32;
   localparam int RANK_W  = 6;
   localparam int COUNT_W = 7;
   localparam logic [VALUE_W-1:0] SIGN_BIAS = 32'h8000_0000;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              last_rank;
   } rsp_type;

   // One loaded set waiting to be ranked.
   typedef struct packed {
      logic               bank;
      logic [COUNT_W-1:0] count;
   } job_type;

   // Back end hands a store bank back to the front end.
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_KEYCAP,
      ST_SCAN,
      ST_EMIT
   } back_state_type;

endpackage
`default_nettype wire

@@ design/vri_ram.sv @@
// Generic single write, single registered read RAM.
`default_nettype none
module vri_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ design/vri_job_fifo.sv @@
// Two entry queue of loaded sets between the front and back ends.
`default_nettype none
`include "assert_macros.svh"
module vri_job_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire vri_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output vri_pkg::job_type      pop_job,
   output logic                  not_empty
);

   vri_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `VRI_NEVER(fifo_no_overflow, push && full && !pop, "job pushed into full queue")
   `VRI_NEVER(fifo_no_underflow, pop && !not_empty, "job popped from empty queue")

endmodule
`default_nettype wire

@@ design/vri_front.sv @@
// Front end: accepts requests, writes the store and queues finished sets.
`default_nettype none
`include "assert_macros.svh"
module vri_front #(
   parameter int MAX_ITEMS = 64,
   parameter int IDX_W     = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire vri_pkg::req_type     req_data,
   output logic                      wr_en,
   output logic [IDX_W:0]            wr_addr,
   output logic [vri_pkg::VALUE_W-1:0] wr_data,
   output logic                      push,
   output vri_pkg::job_type          push_job,
   input  wire logic                 queue_full,
   input  wire vri_pkg::release_type bank_release
);

   logic                          wr_bank_ff, wr_bank_in;
   logic [vri_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [1:0]                    busy_ff, busy_in;
   logic                          accept;
   logic                          room;

   always_comb begin
      req_stall = busy_ff[wr_bank_ff] | queue_full;
      accept    = req_valid & ~req_stall;
      room      = (count_ff < vri_pkg::COUNT_W'(MAX_ITEMS));
      wr_en     = accept & room;
      wr_addr   = {wr_bank_ff, count_ff[IDX_W-1:0]};
      wr_data   = req_data.value;
      push      = accept & req_data.last_item;
      push_job.bank  = wr_bank_ff;
      push_job.count = room ? count_ff + vri_pkg::COUNT_W'(1) : count_ff;

      count_in   = count_ff;
      wr_bank_in = wr_bank_ff;
      busy_in    = busy_ff;
      if (accept) begin
         if (req_data.last_item) begin
            count_in   = '0;
            wr_bank_in = ~wr_bank_ff;
            busy_in[wr_bank_ff] = 1'b1;
         end else if (room) begin
            count_in = count_ff + vri_pkg::COUNT_W'(1);
         end
      end
      // release always names the other bank, so it never clashes with a push
      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_bank_ff <= 1'b0;
         count_ff   <= '0;
         busy_ff    <= '0;
      end else begin
         wr_bank_ff <= wr_bank_in;
         count_ff   <= count_in;
         busy_ff    <= busy_in;
      end
   end

   `VRI_ASSERT(front_count_bound, count_ff <= vri_pkg::COUNT_W'(MAX_ITEMS), "fill count past capacity")

endmodule
`default_nettype wire

@@ design/vri_back.sv @@
// Back end: ranks each stored value of a set and drives the result register.
`default_nettype none
`include "assert_macros.svh"
module vri_back #(
   parameter int IDX_W = 6
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   input  wire vri_pkg::job_type       job,
   output logic                        job_pop,
   output logic [IDX_W:0]              rd_addr,
   input  wire logic [vri_pkg::VALUE_W-1:0] rd_data,
   output vri_pkg::release_type        bank_release,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output vri_pkg::rsp_type            rsp_data
);

   vri_pkg::back_state_type       state_ff, state_in;
   logic [vri_pkg::COUNT_W-1:0]   i_ff, i_in;
   logic [vri_pkg::COUNT_W-1:0]   j_ff, j_in;
   logic [vri_pkg::COUNT_W-1:0]   n_ff, n_in;
   logic                          bank_ff, bank_in;
   logic [vri_pkg::VALUE_W-1:0]   key_ff, key_in;
   logic [vri_pkg::RANK_W-1:0]    cnt_ff, cnt_in;
   vri_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          is_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign is_last   = (i_ff == n_ff - vri_pkg::COUNT_W'(1));

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      bank_in      = bank_ff;
      key_in       = key_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      job_pop      = 1'b0;
      rd_addr      = {bank_ff, i_ff[IDX_W-1:0]};
      bank_release = '0;

      unique case (state_ff)
         vri_pkg::ST_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               n_in     = job.count;
               bank_in  = job.bank;
               i_in     = '0;
               state_in = vri_pkg::ST_KEY;
            end
         end
         vri_pkg::ST_KEY: begin
            state_in = vri_pkg::ST_KEYCAP;
         end
         vri_pkg::ST_KEYCAP: begin
            // bias the sign bit so an unsigned compare orders signed values
            key_in   = rd_data ^ vri_pkg::SIGN_BIAS;
            rd_addr  = {bank_ff, {IDX_W{1'b0}}};
            j_in     = vri_pkg::COUNT_W'(1);
            cnt_in   = '0;
            state_in = vri_pkg::ST_SCAN;
         end
         vri_pkg::ST_SCAN: begin
            // rd_data holds entry j_ff-1 here
            if ((rd_data ^ vri_pkg::SIGN_BIAS) < key_ff) begin
               cnt_in = cnt_ff + vri_pkg::RANK_W'(1);
            end
            if (j_ff < n_ff) begin
               rd_addr = {bank_ff, j_ff[IDX_W-1:0]};
               j_in    = j_ff + vri_pkg::COUNT_W'(1);
            end else begin
               state_in = vri_pkg::ST_EMIT;
            end
         end
         vri_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_in.rank      = cnt_ff;
               rsp_in.last_rank = is_last;
               if (is_last) begin
                  bank_release.valid = 1'b1;
                  bank_release.bank  = bank_ff;
                  state_in           = vri_pkg::ST_IDLE;
               end else begin
                  i_in     = i_ff + vri_pkg::COUNT_W'(1);
                  state_in = vri_pkg::ST_KEY;
               end
            end
         end
         default: begin
            state_in = vri_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vri_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      bank_ff <= bank_in;
      key_ff  <= key_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   `VRI_ASSERT(back_scan_bound, state_ff == vri_pkg::ST_SCAN |-> j_ff <= n_ff, "scan past set end")

endmodule
`default_nettype wire

@@ design/value_rank_indexer.sv @@
// Value rank indexer: top level joining front end, job queue, store and back end.
//
// Requests on req_* carry one signed 32-bit value each; the request flagged
// last_item closes the set. For every loaded value, in load order, one
// response on rsp_* gives its rank (count of set values strictly below it),
// with last_rank set on the final one. Values past MAX_ITEMS are dropped, but
// a dropped request flagged last_item still closes the set.
// Loading takes one request per cycle while req_stall is low. Each response
// for a set of n values is built in steps (key read, key capture, n store
// reads, result load), serialised by the single read port of the store.
// The store has two banks: one set can load while the previous one is
// ranked; req_stall rises only while both banks hold sets not yet ranked.
// A stalled response stays in its output register; the next result load waits.
// Synchronous reset empties the queue and both banks; no clearing pass.
`default_nettype none
module value_rank_indexer #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire vri_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output vri_pkg::rsp_type      rsp_data
);

   localparam int IDX_W       = $clog2(MAX_ITEMS);
   localparam int STORE_DEPTH = 2 * (1 << IDX_W);

   logic                          wr_en;
   logic [IDX_W:0]                wr_addr;
   logic [vri_pkg::VALUE_W-1:0]   wr_data;
   logic [IDX_W:0]                rd_addr;
   logic [vri_pkg::VALUE_W-1:0]   rd_data;
   logic                          push;
   vri_pkg::job_type              push_job;
   logic                          queue_full;
   logic                          pop;
   vri_pkg::job_type              pop_job;
   logic                          queue_not_empty;
   vri_pkg::release_type          bank_release;

   vri_front #(
      .MAX_ITEMS (MAX_ITEMS),
      .IDX_W     (IDX_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .push         (push),
      .push_job     (push_job),
      .queue_full   (queue_full),
      .bank_release (bank_release)
   );

   vri_job_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_job   (pop_job),
      .not_empty (queue_not_empty)
   );

   vri_ram #(
      .WIDTH (vri_pkg::VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vri_back #(
      .IDX_W (IDX_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (queue_not_empty),
      .job          (pop_job),
      .job_pop      (pop),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .bank_release (bank_release),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire
